// ----- design/mrrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrd_pkg
// Shared constants, types and the CRC-16 byte fold for the Modbus reply decoder.
// ----------------------------------------------------------------------------
package mrrd_pkg;

  localparam int          CHANNELS_DEF  = 8;
  localparam int          NREGS         = 8;
  localparam int          REG_IDX_W     = $clog2(NREGS);
  localparam int          NREG_W        = REG_IDX_W + 1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [15:0] FAULT_VALUE   = 16'hFFFF;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [4:0]  POS_MAX       = 5'd31;
  localparam logic [4:0]  POS_COUNT     = 5'd2;
  localparam logic [4:0]  POS_DATA      = 5'd3;
  localparam logic [4:0]  POS_OVERHEAD  = 5'd5;
  localparam logic        REQ_BYTE      = 1'b0;
  localparam logic        REQ_TICK      = 1'b1;

  typedef enum logic [1:0] {
    KIND_CHANNEL,
    KIND_FRAME_STATUS,
    KIND_LINK_DOWN
  } res_kind_t;

  typedef struct packed {
    logic                 take;
    logic                 eval;
    logic                 load;
    res_kind_t            kind;
    logic [REG_IDX_W-1:0] idx;
    logic                 last;
  } ctl_cmd_t;

  typedef struct packed {
    logic              fend;
    logic              drop;
    logic              ok;
    logic [NREG_W-1:0] nreg;
    logic              out_free;
  } dp_stat_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/mrrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrrd_ctrl
// Sequencer: takes input beats, triggers frame evaluation and steps the result
// beats out one per cycle as the output register frees up.
// ----------------------------------------------------------------------------
module mrrd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrrd_pkg::dp_stat_t  stat,
  output mrrd_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT,
    S_DROP
  } state_t;

  state_t                          state_r, state_nxt;
  logic [mrrd_pkg::REG_IDX_W-1:0]  idx_r, idx_nxt;
  logic                            status_only;
  logic                            last_chan;

  assign status_only = !stat.ok || (stat.nreg == '0);
  assign last_chan   = ({1'b0, idx_r} + 1'b1) == stat.nreg;
  assign in_stall    = !rst_n || (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.kind  = mrrd_pkg::KIND_CHANNEL;
    cmd.idx   = idx_r;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        cmd.take = in_valid && rst_n;
        if (cmd.take && stat.fend) begin
          state_nxt = S_EVAL;
        end else if (cmd.take && stat.drop) begin
          state_nxt = S_DROP;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.kind = status_only ? mrrd_pkg::KIND_FRAME_STATUS : mrrd_pkg::KIND_CHANNEL;
        cmd.last = status_only || last_chan;
        if (stat.out_free) begin
          cmd.load = 1'b1;
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_DROP: begin
        cmd.kind = mrrd_pkg::KIND_LINK_DOWN;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- design/mrrd_dp.sv -----
// ----------------------------------------------------------------------------
// mrrd_dp
// Datapath: CRC accumulator, frame position and byte count, register buffer,
// link timer, timeout register and the output register.
// ----------------------------------------------------------------------------
module mrrd_dp #(
  parameter int CHANNELS = mrrd_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrrd_pkg::ctl_cmd_t  cmd,
  output mrrd_pkg::dp_stat_t  stat,
  input  logic                in_req_type,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_frame_end,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          out_channel,
  output logic [15:0]         out_temperature_tenths,
  output logic                out_fault,
  output logic                out_channel_valid,
  output logic                out_crc_ok,
  output logic                out_link_up,
  output logic                out_last
);

  localparam logic [mrrd_pkg::NREG_W-1:0] CH_LIMIT = mrrd_pkg::NREG_W'(CHANNELS);

  logic [15:0] crc_r;
  logic [4:0]  pos_r;
  logic [7:0]  cnt_r;
  logic [15:0] buf_r [mrrd_pkg::NREGS];
  logic        link_r;
  logic [15:0] ms_r;
  logic [15:0] tmo_r;
  logic        ok_r;
  logic [mrrd_pkg::NREG_W-1:0] nreg_r;

  logic        out_valid_r;
  logic [2:0]  out_channel_r;
  logic [15:0] out_temp_r;
  logic        out_fault_r;
  logic        out_chv_r;
  logic        out_ok_r;
  logic        out_link_r;
  logic        out_last_r;

  logic        is_byte;
  logic [15:0] ms_nxt;
  logic [4:0]  d_off;
  logic [3:0]  reg_sel;
  logic [4:0]  data_bytes;
  logic [6:0]  nreg_cnt;
  logic [6:0]  nreg_rx;
  logic [6:0]  nreg_min;
  logic [mrrd_pkg::NREG_W-1:0] nreg_nxt;
  logic [15:0] rd_val;
  logic        rd_fault;

  assign is_byte = (in_req_type == mrrd_pkg::REQ_BYTE);
  assign ms_nxt  = (ms_r == 16'hFFFF) ? ms_r : ms_r + 16'd1;
  assign d_off   = pos_r - mrrd_pkg::POS_DATA;
  assign reg_sel = d_off[4:1];

  assign data_bytes = (pos_r >= mrrd_pkg::POS_OVERHEAD) ? pos_r - mrrd_pkg::POS_OVERHEAD : 5'd0;
  assign nreg_cnt   = cnt_r[7:1];
  assign nreg_rx    = {3'b000, data_bytes[4:1]};
  assign nreg_min   = (nreg_cnt < nreg_rx) ? nreg_cnt : nreg_rx;
  assign nreg_nxt   = (nreg_min > 7'(CH_LIMIT)) ? CH_LIMIT : nreg_min[mrrd_pkg::NREG_W-1:0];

  assign rd_val   = buf_r[cmd.idx];
  assign rd_fault = (rd_val == mrrd_pkg::FAULT_VALUE);

  assign stat.fend     = is_byte && in_frame_end;
  assign stat.drop     = !is_byte && link_r && (ms_nxt > tmo_r);
  assign stat.ok       = ok_r;
  assign stat.nreg     = nreg_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= mrrd_pkg::CRC_INIT;
      pos_r  <= '0;
      cnt_r  <= '0;
      link_r <= 1'b0;
      ms_r   <= '0;
      tmo_r  <= mrrd_pkg::TIMEOUT_RESET;
      ok_r   <= 1'b0;
      nreg_r <= '0;
    end else begin
      if (cfg_valid) begin
        tmo_r <= cfg_data;
      end
      if (cmd.take && is_byte) begin
        crc_r <= mrrd_pkg::crc_fold(crc_r, in_rx_byte);
        if (pos_r == mrrd_pkg::POS_COUNT) begin
          cnt_r <= in_rx_byte;
        end
        if (pos_r < mrrd_pkg::POS_MAX) begin
          pos_r <= pos_r + 5'd1;
        end
        if (in_frame_end) begin
          link_r <= 1'b1;
          ms_r   <= '0;
        end
      end
      if (cmd.take && !is_byte) begin
        ms_r <= ms_nxt;
        if (stat.drop) begin
          link_r <= 1'b0;
        end
      end
      if (cmd.eval) begin
        ok_r   <= (crc_r == 16'h0000);
        nreg_r <= nreg_nxt;
        crc_r  <= mrrd_pkg::CRC_INIT;
        pos_r  <= '0;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_byte && (pos_r >= mrrd_pkg::POS_DATA) && !reg_sel[3]) begin
      if (!d_off[0]) begin
        buf_r[reg_sel[2:0]][15:8] <= in_rx_byte;
      end else begin
        buf_r[reg_sel[2:0]][7:0] <= in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_last_r <= cmd.last;
      case (cmd.kind)
        mrrd_pkg::KIND_CHANNEL: begin
          out_channel_r <= 3'(cmd.idx);
          out_temp_r    <= rd_fault ? 16'h0000 : rd_val;
          out_fault_r   <= rd_fault;
          out_chv_r     <= 1'b1;
          out_ok_r      <= 1'b1;
          out_link_r    <= 1'b1;
        end
        mrrd_pkg::KIND_FRAME_STATUS: begin
          out_channel_r <= '0;
          out_temp_r    <= '0;
          out_fault_r   <= 1'b0;
          out_chv_r     <= 1'b0;
          out_ok_r      <= ok_r;
          out_link_r    <= 1'b1;
        end
        default: begin
          out_channel_r <= '0;
          out_temp_r    <= '0;
          out_fault_r   <= 1'b0;
          out_chv_r     <= 1'b0;
          out_ok_r      <= 1'b0;
          out_link_r    <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_channel            = out_channel_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_fault              = out_fault_r;
  assign out_channel_valid      = out_chv_r;
  assign out_crc_ok             = out_ok_r;
  assign out_link_up            = out_link_r;
  assign out_last               = out_last_r;

endmodule

// ----- design/modbus_register_reply_decoder_core.sv -----
// ----------------------------------------------------------------------------
// modbus_register_reply_decoder_core
// Modbus RTU read-holding-registers reply decoder with link supervision.
// ----------------------------------------------------------------------------
// Reply bytes and millisecond ticks enter on the in_ channel, one beat each.
// The CRC-16 fold of a byte is done in the cycle in which the byte is taken.
// The byte that ends a frame leads to an evaluation step, then one result
// beat per register, up to CHANNELS, or a single status beat; the input stays
// stalled until the last result is loaded into the output register. A tick
// that times out the link gives one status beat. The timeout in ms is written
// through cfg_; the user must write it only while the block is idle, which the
// block itself does not enforce; reset value 2000.
// ----------------------------------------------------------------------------
module modbus_register_reply_decoder_core #(
  parameter int CHANNELS = mrrd_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_channel,
  output logic [15:0] out_temperature_tenths,
  output logic        out_fault,
  output logic        out_channel_valid,
  output logic        out_crc_ok,
  output logic        out_link_up,
  output logic        out_last
);

  mrrd_pkg::ctl_cmd_t cmd;
  mrrd_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  mrrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrrd_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_req_type            (in_req_type),
    .in_rx_byte             (in_rx_byte),
    .in_frame_end           (in_frame_end),
    .cfg_valid              (cfg_valid && cfg_ready),
    .cfg_data               (cfg_data),
    .out_stall              (out_stall),
    .out_valid              (out_valid),
    .out_channel            (out_channel),
    .out_temperature_tenths (out_temperature_tenths),
    .out_fault              (out_fault),
    .out_channel_valid      (out_channel_valid),
    .out_crc_ok             (out_crc_ok),
    .out_link_up            (out_link_up),
    .out_last               (out_last)
  );

  a_chan_implies_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel_valid |-> out_crc_ok && out_link_up)
    else $error("channel beat without good frame");

  a_fault_zero_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_temperature_tenths == 16'h0000 && out_channel_valid)
    else $error("fault beat carries temperature");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_channel_valid |-> out_last)
    else $error("status beat not marked last");

  a_stall_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && !cmd.last |=> in_stall)
    else $error("input taken during result burst");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modbus_register_reply_decoder_core: random Modbus
// replies (well-formed, miscounted, oversized, corrupted, noise) and ms ticks
// are pushed through a bursty sender against a stalling receiver. A scoreboard
// predicts every channel and status beat and compares it field by field,
// across several link timeout settings including both extremes.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CYCLE_LIMIT       = 1000000;
  localparam int          DRAIN_CYCLES      = 24;
  localparam int          HOLD_CYCLES       = 150;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] tenths;
    logic        fault;
    logic        chan_valid;
    logic        crc_ok;
    logic        link_up;
    logic        last;
  } reading_t;

  class modbus_reply_tracker;
    reading_t    pending_readings[$];
    logic [15:0] timeout_ms;
    logic [15:0] crc_acc;
    logic [15:0] ms_count;
    logic [4:0]  pos;
    logic [7:0]  count_field;
    logic [15:0] regs[mrrd_pkg::NREGS];
    logic        link;
    int          fails, n_bytes, n_ticks, n_frames, n_drops, n_checked;

    function new();
      timeout_ms  = mrrd_pkg::TIMEOUT_RESET;
      crc_acc     = mrrd_pkg::CRC_INIT;
      ms_count    = '0;
      pos         = '0;
      count_field = '0;
      link        = 1'b0;
      foreach (regs[i]) regs[i] = '0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ mrrd_pkg::CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void set_timeout(logic [15:0] v);
      timeout_ms = v;
    endfunction

    function void take_beat(logic req, logic [7:0] b, logic fe);
      reading_t r;
      int       d, seen, data, nreg;
      bit       ok;
      r = '0;
      if (req == mrrd_pkg::REQ_TICK) begin
        n_ticks++;
        if (ms_count != 16'hFFFF) ms_count++;
        if (link && ms_count > timeout_ms) begin
          link = 1'b0;
          n_drops++;
          r.last = 1'b1;
          pending_readings.push_back(r);
        end
        return;
      end
      n_bytes++;
      crc_acc = crc_step(crc_acc, b);
      if (pos == mrrd_pkg::POS_COUNT) begin
        count_field = b;
      end else if (pos >= mrrd_pkg::POS_DATA) begin
        d = int'(pos - mrrd_pkg::POS_DATA);
        if ((d >> 1) < mrrd_pkg::NREGS) begin
          if (d[0] == 1'b0) begin
            regs[d >> 1][15:8] = b;
          end else begin
            regs[d >> 1][7:0] = b;
          end
        end
      end
      if (pos < mrrd_pkg::POS_MAX) pos++;
      if (!fe) return;

      n_frames++;
      seen = int'(pos);
      data = (seen >= int'(mrrd_pkg::POS_OVERHEAD)) ?
             seen - int'(mrrd_pkg::POS_OVERHEAD) : 0;
      nreg = int'(count_field) / 2;
      if (nreg > data / 2) nreg = data / 2;
      if (nreg > mrrd_pkg::CHANNELS_DEF) nreg = mrrd_pkg::CHANNELS_DEF;
      if (nreg > mrrd_pkg::NREGS) nreg = mrrd_pkg::NREGS;
      ok = (crc_acc == 16'h0000);
      link        = 1'b1;
      ms_count    = '0;
      crc_acc     = mrrd_pkg::CRC_INIT;
      pos         = '0;
      count_field = '0;
      if (!ok || nreg == 0) begin
        r.crc_ok  = ok;
        r.link_up = 1'b1;
        r.last    = 1'b1;
        pending_readings.push_back(r);
        return;
      end
      for (int i = 0; i < nreg; i++) begin
        r.channel    = 3'(i);
        r.fault      = (regs[i] == mrrd_pkg::FAULT_VALUE);
        r.tenths     = r.fault ? 16'h0000 : regs[i];
        r.chan_valid = 1'b1;
        r.crc_ok     = 1'b1;
        r.link_up    = 1'b1;
        r.last       = (i == nreg - 1);
        pending_readings.push_back(r);
      end
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        fails++;
      end
    endfunction

    function void match_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        $error("unexpected beat: channel %0d tenths %0h", got.channel, got.tenths);
        fails++;
        return;
      end
      want = pending_readings.pop_front();
      n_checked++;
      field_check("channel", 16'(want.channel), 16'(got.channel));
      field_check("temperature_tenths", want.tenths, got.tenths);
      field_check("fault", 16'(want.fault), 16'(got.fault));
      field_check("channel_valid", 16'(want.chan_valid), 16'(got.chan_valid));
      field_check("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
      field_check("link_up", 16'(want.link_up), 16'(got.link_up));
      field_check("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        in_req_type  = mrrd_pkg::REQ_BYTE;
  logic [7:0]  in_rx_byte   = 8'h00;
  logic        in_frame_end = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data     = 16'h0000;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [2:0]  out_channel;
  logic [15:0] out_temperature_tenths;
  logic        out_fault;
  logic        out_channel_valid;
  logic        out_crc_ok;
  logic        out_link_up;
  logic        out_last;

  int cycle_count = 0;
  int beats_sent  = 0;
  int burst_left  = 0;
  bit pace_on     = 1'b1;
  int hold_ticket = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int rx_seg_left = 0;
  int rx_style    = 0;

  modbus_reply_tracker tracker;

  modbus_register_reply_decoder_core DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_req_type            (in_req_type),
    .in_rx_byte             (in_rx_byte),
    .in_frame_end           (in_frame_end),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_data               (cfg_data),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_channel            (out_channel),
    .out_temperature_tenths (out_temperature_tenths),
    .out_fault              (out_fault),
    .out_channel_valid      (out_channel_valid),
    .out_crc_ok             (out_crc_ok),
    .out_link_up            (out_link_up),
    .out_last               (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin : watch
    reading_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.channel    = out_channel;
        got.tenths     = out_temperature_tenths;
        got.fault      = out_fault;
        got.chan_valid = out_channel_valid;
        got.crc_ok     = out_crc_ok;
        got.link_up    = out_link_up;
        got.last       = out_last;
        tracker.match_reading(got);
      end
      if (in_valid && !in_stall) tracker.take_beat(in_req_type, in_rx_byte, in_frame_end);
      if (cfg_valid && cfg_ready) tracker.set_timeout(cfg_data);
    end
  end

  // receiver: random stall segments, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_seg_left == 0) begin
        rx_seg_left <= $urandom_range(4, 60);
        rx_style    <= $urandom_range(0, 3);
      end else begin
        rx_seg_left <= rx_seg_left - 1;
      end
      case (rx_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic [15:0] pick_reading();
    case ($urandom_range(0, 7))
      0: return mrrd_pkg::FAULT_VALUE;
      1: return 16'h0000;
      2: return 16'hFFFE;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_beat(logic req, logic [7:0] b, logic fe);
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_rx_byte   <= b;
    in_frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic idle_for(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic offer(logic req, logic [7:0] b, logic fe);
    if (pace_on) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 6));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      end
      burst_left--;
    end
    send_beat(req, b, fe);
  endtask

  task automatic send_frame(byte_q_t fr, bit seal, bit corrupt);
    logic [15:0] crc;
    int          k;
    crc = mrrd_pkg::CRC_INIT;
    if (seal) begin
      foreach (fr[i]) crc = modbus_reply_tracker::crc_step(crc, fr[i]);
      fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
    end
    if (corrupt) begin
      k = $urandom_range(0, fr.size() - 1);
      fr[k] = fr[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (fr[i]) offer(mrrd_pkg::REQ_BYTE, fr[i], i == fr.size() - 1);
  endtask

  task automatic random_reply(int nregs, bit odd_count, bit corrupt);
    byte_q_t     fr;
    logic [15:0] v;
    fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : FUNC_READ_HOLDING);
    fr.push_back(odd_count ? 8'($urandom_range(0, 255)) : 8'(2 * nregs));
    repeat (nregs) begin
      v = pick_reading();
      fr.push_back(v[15:8]);
      fr.push_back(v[7:0]);
    end
    send_frame(fr, 1'b1, corrupt);
  endtask

  task automatic send_ticks(int n);
    repeat (n) offer(mrrd_pkg::REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_traffic(int n);
    int      stop_at, pick;
    byte_q_t fr;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        random_reply($urandom_range(1, 8), 1'b0, 1'b0);
      end else if (pick < 58) begin
        random_reply($urandom_range(0, 14), 1'b1, 1'b0);
      end else if (pick < 64) begin
        random_reply($urandom_range(9, 14), 1'b0, 1'b0);
      end else if (pick < 72) begin
        random_reply($urandom_range(0, 8), 1'b0, 1'b1);
      end else if (pick < 76) begin
        random_reply(0, 1'b0, 1'b0);
      end else if (pick < 82) begin
        fr.delete();
        repeat ($urandom_range(1, 6)) fr.push_back(8'($urandom_range(0, 255)));
        send_frame(fr, 1'b0, 1'b0);
      end else begin
        send_ticks($urandom_range(1, 14));
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    byte_q_t     fr;
    logic [15:0] mid_timeout;
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick while link down, fault and zero registers, one-byte bad frame, empty reply
    offer(mrrd_pkg::REQ_TICK, 8'hFF, 1'b1);
    fr = '{8'hFF, FUNC_READ_HOLDING, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_frame(fr, 1'b1, 1'b0);
    fr = '{8'h00};
    send_frame(fr, 1'b0, 1'b0);
    fr = '{8'h01, FUNC_READ_HOLDING, 8'h00};
    send_frame(fr, 1'b1, 1'b0);
    offer(mrrd_pkg::REQ_TICK, 8'h00, 1'b0);

    random_traffic(15);
    random_reply(1, 1'b0, 1'b0);
    pace_on = 1'b0;
    send_ticks(10);
    pace_on = 1'b1;

    settle();
    write_timeout(16'h0000);
    random_traffic(12);

    settle();
    write_timeout(16'h0001);
    hold_ticket <= hold_ticket + 1;
    repeat (2) random_reply(8, 1'b0, 1'b0);
    random_traffic(12);

    settle();
    mid_timeout = 16'($urandom_range(2, 12));
    write_timeout(mid_timeout);
    random_traffic(20);

    settle();
    write_timeout(16'hFFFF);
    random_reply(2, 1'b0, 1'b0);
    pace_on = 1'b0;
    send_ticks(10);
    pace_on = 1'b1;
    random_traffic(12);

    settle();
    if (tracker.pending_readings.size() != 0) begin
      $error("%0d expected beats never arrived", tracker.pending_readings.size());
      tracker.fails++;
    end
    $display("covered %0d reply bytes, %0d ms ticks, %0d frame ends, %0d link drops",
             tracker.n_bytes, tracker.n_ticks, tracker.n_frames, tracker.n_drops);
    $display("%0d result beats checked with timeouts 2000, 0, 1, %0d and 65535",
             tracker.n_checked, mid_timeout);
    if (tracker.fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- modbus_register_reply_decoder_core.f -----
design/mrrd_pkg.sv
design/mrrd_ctrl.sv
design/mrrd_dp.sv
design/modbus_register_reply_decoder_core.sv
bench/tb.sv
